[rtl/psc_pkg.sv]
// Shared constants, codes and command/status types for the postfix stack calculator.
// Depends on nothing; every other file except psc_ram imports it.

package psc_pkg;

    localparam int STACK_DEPTH = 64;
    localparam int WORD_W      = 12;
    localparam int PTR_W       = $clog2(STACK_DEPTH);
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
    localparam int DEPTH_W     = 7;
    localparam int MODE_W      = 3;
    localparam int ERR_W       = 2;
    localparam int DIV_CNT_W   = $clog2(WORD_W);

    localparam logic [MODE_W-1:0] MODE_PUSH = 3'd0;
    localparam logic [MODE_W-1:0] MODE_ADD  = 3'd1;
    localparam logic [MODE_W-1:0] MODE_SUB  = 3'd2;
    localparam logic [MODE_W-1:0] MODE_MUL  = 3'd3;
    localparam logic [MODE_W-1:0] MODE_DIV  = 3'd4;
    localparam logic [MODE_W-1:0] MODE_MOD  = 3'd5;

    localparam logic [ERR_W-1:0] ERR_OK      = 2'd0;
    localparam logic [ERR_W-1:0] ERR_UNDER   = 2'd1;
    localparam logic [ERR_W-1:0] ERR_OVER    = 2'd2;
    localparam logic [ERR_W-1:0] ERR_DIVZERO = 2'd3;

    typedef logic [WORD_W-1:0] word_t;

    // Controller to datapath
    typedef struct packed {
        logic             latch_in;   // capture the input transfer
        logic             push;       // write operand above the top
        logic             wb;         // write result over the second entry and pop
        logic             div_start;  // load the divider
        logic             div_step;   // one restoring division step
        logic             load_out;   // fill the output register
        logic [ERR_W-1:0] err;        // error code to report
    } psc_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic              full;
        logic              under;
        logic              b_zero;
        logic              div_last;
        logic              out_free;
    } psc_sts_t;

endpackage

[rtl/psc_ram.sv]
// Generic single-clock RAM: one write port, one read port, registered read data.
// Depends on nothing.

module psc_ram #(
    parameter int WIDTH = 12,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

[rtl/psc_dpath.sv]
// Datapath: stack RAM, cached top entry, entry count, ALU, iterative divider, output register.
// Depends on psc_pkg and psc_ram.

module psc_dpath
    import psc_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  psc_cmd_t            cmd,
    output psc_sts_t            sts,
    input  logic [MODE_W-1:0]   s_mode,
    input  logic [WORD_W-1:0]   s_value,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [WORD_W-1:0]   m_top_value,
    output logic                m_top_valid,
    output logic [DEPTH_W-1:0]  m_depth,
    output logic [ERR_W-1:0]    m_error
);

    logic [MODE_W-1:0]    mode_reg;
    word_t                value_reg;
    logic [CNT_W-1:0]     count_reg, count_next;
    word_t                top_reg, top_next;
    word_t                quo_reg, quo_next;
    word_t                rem_reg, rem_next;
    logic [DIV_CNT_W-1:0] div_cnt_reg, div_cnt_next;

    logic                 out_valid_reg;
    word_t                out_top_reg;
    logic                 out_tv_reg;
    logic [DEPTH_W-1:0]   out_depth_reg;
    logic [ERR_W-1:0]     out_err_reg;

    logic [CNT_W-1:0]     below_cnt;
    logic [PTR_W-1:0]     wr_addr;
    word_t                wr_data;
    word_t                opnd_a;
    word_t                alu_res;
    word_t                wb_data;
    logic [2*WORD_W-1:0]  prod;
    logic [WORD_W+1:0]    trial;

    // Index of the entry beneath the top
    assign below_cnt = count_reg - CNT_W'(2);

    assign wr_addr = cmd.push ? count_reg[PTR_W-1:0] : below_cnt[PTR_W-1:0];
    assign wr_data = cmd.push ? value_reg : wb_data;

    psc_ram #(
        .WIDTH (WORD_W),
        .DEPTH (STACK_DEPTH)
    ) u_ram (
        .clk     (aclk),
        .wr_en   (cmd.push | cmd.wb),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (below_cnt[PTR_W-1:0]),
        .rd_data (opnd_a)
    );

    assign prod = {{WORD_W{1'b0}}, opnd_a} * {{WORD_W{1'b0}}, top_reg};

    always_comb begin
        case (mode_reg)
            MODE_ADD: alu_res = opnd_a + top_reg;
            MODE_SUB: alu_res = opnd_a - top_reg;
            MODE_MUL: alu_res = prod[WORD_W-1:0];
            default:  alu_res = opnd_a + top_reg;
        endcase
    end

    always_comb begin
        case (mode_reg)
            MODE_DIV: wb_data = quo_reg;
            MODE_MOD: wb_data = rem_reg;
            default:  wb_data = alu_res;
        endcase
    end

    // Restoring division: shift dividend bits in from the quotient register
    assign trial = {1'b0, rem_reg, quo_reg[WORD_W-1]} - {2'b00, top_reg};

    always_comb begin
        quo_next     = quo_reg;
        rem_next     = rem_reg;
        div_cnt_next = div_cnt_reg;
        if (cmd.div_start) begin
            quo_next     = opnd_a;
            rem_next     = '0;
            div_cnt_next = '0;
        end else if (cmd.div_step) begin
            div_cnt_next = div_cnt_reg + DIV_CNT_W'(1);
            if (trial[WORD_W+1]) begin
                rem_next = {rem_reg[WORD_W-2:0], quo_reg[WORD_W-1]};
                quo_next = {quo_reg[WORD_W-2:0], 1'b0};
            end else begin
                rem_next = trial[WORD_W-1:0];
                quo_next = {quo_reg[WORD_W-2:0], 1'b1};
            end
        end
    end

    always_comb begin
        count_next = count_reg;
        top_next   = top_reg;
        if (cmd.push) begin
            count_next = count_reg + CNT_W'(1);
            top_next   = value_reg;
        end else if (cmd.wb) begin
            count_next = count_reg - CNT_W'(1);
            top_next   = wb_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            count_reg <= count_next;
            if (cmd.load_out) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.latch_in) begin
            mode_reg  <= s_mode;
            value_reg <= s_value;
        end
        top_reg     <= top_next;
        quo_reg     <= quo_next;
        rem_reg     <= rem_next;
        div_cnt_reg <= div_cnt_next;
        if (cmd.load_out) begin
            out_top_reg   <= (count_reg != '0) ? top_reg : '0;
            out_tv_reg    <= (count_reg != '0);
            out_depth_reg <= DEPTH_W'(count_reg);
            out_err_reg   <= cmd.err;
        end
    end

    assign sts.mode     = mode_reg;
    assign sts.full     = (count_reg == CNT_W'(STACK_DEPTH));
    assign sts.under    = (count_reg < CNT_W'(2));
    assign sts.b_zero   = (top_reg == '0);
    assign sts.div_last = (div_cnt_reg == DIV_CNT_W'(WORD_W - 1));
    assign sts.out_free = !out_valid_reg || m_ready;

    assign m_valid     = out_valid_reg;
    assign m_top_value = out_top_reg;
    assign m_top_valid = out_tv_reg;
    assign m_depth     = out_depth_reg;
    assign m_error     = out_err_reg;

endmodule

[rtl/psc_ctrl.sv]
// Controller state machine: sequences push, operator, divide and result transfer.
// Depends on psc_pkg.

module psc_ctrl
    import psc_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  psc_sts_t sts,
    output psc_cmd_t cmd
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_EXEC = 3'd1;
    localparam logic [2:0] ST_WAIT = 3'd2;
    localparam logic [2:0] ST_DIV  = 3'd3;
    localparam logic [2:0] ST_WB   = 3'd4;
    localparam logic [2:0] ST_DONE = 3'd5;

    logic [2:0]       state_reg, state_next;
    logic [ERR_W-1:0] err_reg, err_next;

    assign s_ready = (state_reg == ST_IDLE);

    always_comb begin
        state_next    = state_reg;
        err_next      = err_reg;
        cmd           = '0;
        cmd.err       = err_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.latch_in = 1'b1;
                    state_next   = ST_EXEC;
                end
            end
            ST_EXEC: begin
                state_next = ST_DONE;
                case (sts.mode)
                    MODE_PUSH: begin
                        if (sts.full) begin
                            err_next = ERR_OVER;
                        end else begin
                            cmd.push = 1'b1;
                            err_next = ERR_OK;
                        end
                    end
                    MODE_ADD, MODE_SUB, MODE_MUL, MODE_DIV, MODE_MOD: begin
                        if (sts.under) begin
                            err_next = ERR_UNDER;
                        end else begin
                            err_next   = ERR_OK;
                            state_next = ST_WAIT;
                        end
                    end
                    default: begin
                        err_next = ERR_OK;
                    end
                endcase
            end
            ST_WAIT: begin
                if (sts.mode == MODE_DIV || sts.mode == MODE_MOD) begin
                    if (sts.b_zero) begin
                        err_next   = ERR_DIVZERO;
                        state_next = ST_DONE;
                    end else begin
                        cmd.div_start = 1'b1;
                        state_next    = ST_DIV;
                    end
                end else begin
                    cmd.wb     = 1'b1;
                    state_next = ST_DONE;
                end
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                if (sts.div_last) begin
                    state_next = ST_WB;
                end
            end
            ST_WB: begin
                cmd.wb     = 1'b1;
                state_next = ST_DONE;
            end
            ST_DONE: begin
                if (sts.out_free) begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            err_reg   <= ERR_OK;
        end else begin
            state_reg <= state_next;
            err_reg   <= err_next;
        end
    end

endmodule

[rtl/postfix_stack_calculator.sv]
// Top level of the postfix stack calculator: joins controller and datapath.
// Depends on psc_pkg, psc_ctrl and psc_dpath (which holds the psc_ram stack).
//
// Usage:
//   Input channel (s_valid/s_ready, s_mode, s_value): each transfer is one step:
//   push s_value (mode 0) or apply add, subtract, multiply, divide or modulo
//   (modes 1..5) to the two top entries, popping both and pushing the result.
//   Modes 6 and 7 leave the stack alone and report it with no error.
//   Result channel (m_valid/m_ready): exactly one result per step, carrying the
//   top entry (zero when empty), a non-empty flag, the depth and an error code
//   (underflow, overflow, divide by zero; on any error the stack is unchanged).
//   From an input transfer the controller runs EXEC then DONE for push, ignored
//   modes and underflow; EXEC, WAIT and DONE for add/subtract/multiply and divide
//   by zero; EXEC, WAIT, DIV, WB and DONE for divide and modulo. One step is in
//   work at a time; the next input transfer is taken the cycle after the result
//   is loaded in DONE. WAIT covers the registered stack RAM read; DIV runs the
//   12 iterations of the restoring divider, and WB writes the result back.
//   The result sits in an output register. While the receiver stalls, hold it
//   there; the next step still runs, then waits with the input closed until
//   m_ready frees the register.
//   Reset (aresetn low, synchronous) empties the stack and drops any pending
//   result; RAM contents need no clearing since only written entries are read.

module postfix_stack_calculator
    import psc_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [MODE_W-1:0]  s_mode,
    input  logic [WORD_W-1:0]  s_value,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [WORD_W-1:0]  m_top_value,
    output logic               m_top_valid,
    output logic [DEPTH_W-1:0] m_depth,
    output logic [ERR_W-1:0]   m_error
);

    // Command and status between the two halves
    psc_cmd_t cmd;
    psc_sts_t sts;

    psc_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    psc_dpath u_dpath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .sts         (sts),
        .s_mode      (s_mode),
        .s_value     (s_value),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_top_value (m_top_value),
        .m_top_valid (m_top_valid),
        .m_depth     (m_depth),
        .m_error     (m_error)
    );

endmodule

[rtl/psc_checker.sv]
// Port-level checks on the postfix stack calculator, bound to the top level.
// Depends on psc_pkg for field widths.

module psc_checker
    import psc_pkg::*;
(
    input logic               aclk,
    input logic               aresetn,
    input logic               s_valid,
    input logic               s_ready,
    input logic               m_valid,
    input logic               m_ready,
    input logic [WORD_W-1:0]  m_top_value,
    input logic               m_top_valid,
    input logic [DEPTH_W-1:0] m_depth,
    input logic [ERR_W-1:0]   m_error
);

    // Reset drops any pending result
    a_reset_clears: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // One step at a time: a transfer closes the input until the step completes
    a_one_step: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input taken while a step is in work");

    // Hold the result while the receiver stalls
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_top_value) && $stable(m_top_valid)
            && $stable(m_depth) && $stable(m_error))
        else $error("stalled result changed");

    // Non-empty flag agrees with the depth; an empty stack reports zero
    a_top_consistent: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_top_valid == (m_depth != '0))
            && (m_top_valid || (m_top_value == '0)))
        else $error("top flag, value and depth disagree");

endmodule

bind postfix_stack_calculator psc_checker u_psc_checker (.*);

[bench/postfix_stack_calculator_test.sv]
// Self-checking testbench for postfix_stack_calculator: directed and random RPN steps.
// It keeps a shadow stack of its own that predicts every report and checks each one.
// Depends on psc_pkg and the postfix_stack_calculator RTL.

module postfix_stack_calculator_test;
    import psc_pkg::*;

    // Mode codes that the block ignores; the package names only the live ones.
    localparam logic [MODE_W-1:0] MODE_SPARE_LO = 3'd6;
    localparam logic [MODE_W-1:0] MODE_SPARE_HI = 3'd7;

    localparam int IDLE_PCT      = 30;   // share of cycles either side holds back
    localparam int RANDOM_STEPS  = 1625; // counted random steps after the directed part
    localparam int SEGMENT_STEPS = 120;  // steps per push-bias segment
    localparam int STEADY_FROM   = 700;  // no idling on either side in this window
    localparam int STEADY_TO     = 1000;
    localparam int STALL_LIMIT   = 2000; // cycles with no transfer before giving up
    localparam int DRAIN_CYCLES  = 40;   // longest step is a divide; allow well over

    // One report as the result channel carries it.
    typedef struct packed {
        word_t              top_value;
        logic               top_valid;
        logic [DEPTH_W-1:0] depth;
        logic [ERR_W-1:0]   error;
    } stack_report_t;

    // Shadow stack: predicts the report of each accepted step and checks the
    // reports coming back in order.
    class stack_shadow;
        word_t         words [STACK_DEPTH];
        int unsigned   entries;
        stack_report_t due_reports [$];
        int unsigned   failures;

        function new();
            entries  = 0;
            failures = 0;
        endfunction

        function int unsigned pending();
            return due_reports.size();
        endfunction

        // Note an accepted input transfer and queue the report it must cause.
        function void note_step(logic [MODE_W-1:0] mode, word_t value);
            word_t            lhs;
            word_t            rhs;
            word_t            res;
            logic [ERR_W-1:0] code;
            stack_report_t    rep;
            code = ERR_OK;
            res  = '0;
            if (mode == MODE_PUSH) begin
                if (entries >= STACK_DEPTH) begin
                    code = ERR_OVER;
                end else begin
                    words[entries] = value;
                    entries++;
                end
            end else if (mode <= MODE_MOD) begin
                if (entries < 2) begin
                    code = ERR_UNDER;
                end else begin
                    rhs = words[entries - 1];
                    lhs = words[entries - 2];
                    case (mode)
                        MODE_ADD: res = lhs + rhs;
                        MODE_SUB: res = lhs - rhs;
                        MODE_MUL: res = lhs * rhs;
                        MODE_DIV: begin
                            if (rhs == '0) code = ERR_DIVZERO;
                            else res = lhs / rhs;
                        end
                        default: begin
                            if (rhs == '0) code = ERR_DIVZERO;
                            else res = lhs % rhs;
                        end
                    endcase
                    if (code == ERR_OK) begin
                        entries--;
                        words[entries - 1] = res;
                    end
                end
            end
            rep.top_valid = (entries != 0);
            rep.top_value = (entries != 0) ? words[entries - 1] : '0;
            rep.depth     = DEPTH_W'(entries);
            rep.error     = code;
            due_reports.push_back(rep);
        endfunction

        function void compare_field(string name, word_t want, word_t got);
            if (got !== want) begin
                $error("%s: expected %0d, got %0d", name, want, got);
                failures++;
            end
        endfunction

        // Check one accepted result against the oldest queued report.
        function void check_report(word_t top_value, logic top_valid,
                                   logic [DEPTH_W-1:0] depth, logic [ERR_W-1:0] error);
            stack_report_t rep;
            if (due_reports.size() == 0) begin
                $error("result transfer with no step outstanding");
                failures++;
            end else begin
                rep = due_reports.pop_front();
                compare_field("top_value", rep.top_value, top_value);
                compare_field("top_valid", word_t'(rep.top_valid), word_t'(top_valid));
                compare_field("depth", word_t'(rep.depth), word_t'(depth));
                compare_field("error", word_t'(rep.error), word_t'(error));
            end
        endfunction
    endclass

    logic               aclk    = 1'b0;
    logic               aresetn = 1'b0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    logic [MODE_W-1:0]  s_mode  = MODE_PUSH;
    logic [WORD_W-1:0]  s_value = '0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic [WORD_W-1:0]  m_top_value;
    logic               m_top_valid;
    logic [DEPTH_W-1:0] m_depth;
    logic [ERR_W-1:0]   m_error;

    stack_shadow shadow = new();
    bit          steady = 1'b0;  // set: neither side idles

    postfix_stack_calculator i_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_mode      (s_mode),
        .s_value     (s_value),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_top_value (m_top_value),
        .m_top_valid (m_top_valid),
        .m_depth     (m_depth),
        .m_error     (m_error)
    );

    initial begin
        forever #1 aclk = ~aclk;
    end

    // Operand mix: lean on zero (divide-by-zero), all-ones (wrap) and small
    // values (non-trivial quotients), with plenty of full-range values too.
    function automatic word_t pick_operand();
        case ($urandom_range(7))
            0:       return '0;
            1:       return '1;
            2:       return word_t'($urandom_range(15, 1));
            default: return word_t'($urandom_range(4095));
        endcase
    endfunction

    function automatic logic [MODE_W-1:0] pick_operator();
        return MODE_W'($urandom_range(MODE_MOD, MODE_ADD));
    endfunction

    function automatic logic [MODE_W-1:0] pick_spare();
        return $urandom_range(1) ? MODE_SPARE_HI : MODE_SPARE_LO;
    endfunction

    // Offer one step on the input channel. Idle at random first (valid low),
    // then raise valid and hold it with the payload until the transfer.
    task automatic drive_step(input logic [MODE_W-1:0] mode, input word_t value);
        while (!steady && $urandom_range(99) < IDLE_PCT) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_mode  <= mode;
        s_value <= value;
        do @(posedge aclk); while (s_ready !== 1'b1);
        shadow.note_step(mode, value);
    endtask

    // Result side: check every transfer, then pick next cycle's ready.
    // Sampling at the edge sees the values from before the edge, so the
    // block's own updates at this edge cannot leak in.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            shadow.check_report(m_top_value, m_top_valid, m_depth, m_error);
        m_ready <= steady || ($urandom_range(99) >= IDLE_PCT);
    end

    // Watchdog: end the run if no transfer happens on either channel for too long.
    initial begin : watchdog
        int unsigned quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("postfix_stack_calculator regression: fail");
        $finish;
    end

    initial begin : stimulus
        int unsigned counted;
        int unsigned push_pct;

        // Hold reset low at the start, then release it.
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed part: underflow on an empty and a one-entry stack, ignored
        // modes, wrap-around on add, subtract and multiply, divide and modulo
        // by zero, plain divide and modulo, and alternating bit patterns.
        drive_step(MODE_ADD, word_t'($urandom_range(4095)));
        drive_step(MODE_SPARE_LO, word_t'($urandom_range(4095)));
        drive_step(MODE_PUSH, 12'hFFF);
        drive_step(MODE_MOD, word_t'($urandom_range(4095)));
        drive_step(MODE_PUSH, 12'hFFF);
        drive_step(MODE_ADD, '0);                          // 4095 + 4095 wraps
        drive_step(MODE_PUSH, 12'hFFF);
        drive_step(MODE_SUB, '0);                          // goes below zero, wraps
        drive_step(MODE_PUSH, 12'hFFF);
        drive_step(MODE_MUL, '0);                          // keep low 12 bits only
        drive_step(MODE_PUSH, '0);
        drive_step(MODE_DIV, 12'hFFF);                     // divide by zero
        drive_step(MODE_MOD, 12'hFFF);                     // modulo by zero
        drive_step(MODE_SUB, '0);
        drive_step(MODE_PUSH, 12'd3000);
        drive_step(MODE_SUB, '0);
        drive_step(MODE_PUSH, 12'd7);
        drive_step(MODE_MOD, '0);
        drive_step(MODE_PUSH, 12'd5);
        drive_step(MODE_DIV, '0);
        drive_step(MODE_SPARE_HI, 12'hFFF);
        drive_step(MODE_MUL, '0);                          // one entry: underflow
        drive_step(MODE_PUSH, 12'o5252);
        drive_step(MODE_PUSH, 12'o2525);
        drive_step(MODE_SUB, '0);

        // Random part in segments of varying push bias: balanced, fill (drives
        // the stack into overflow), balanced and drain. Below two entries mostly
        // push, so operators usually find operands; the remainder is underflow
        // noise. Ignored modes are sprinkled in and not counted.
        counted = 0;
        while (counted < RANDOM_STEPS) begin
            steady = (counted >= STEADY_FROM) && (counted < STEADY_TO);
            case ((counted / SEGMENT_STEPS) % 4)
                0:       push_pct = 55;
                1:       push_pct = 90;
                2:       push_pct = 50;
                default: push_pct = 30;
            endcase
            if (shadow.entries < 2)
                push_pct = 92;
            if ($urandom_range(99) < 3) begin
                drive_step(pick_spare(), word_t'($urandom_range(4095)));
            end else begin
                if ($urandom_range(99) < push_pct)
                    drive_step(MODE_PUSH, pick_operand());
                else
                    drive_step(pick_operator(), word_t'($urandom_range(4095)));
                counted++;
            end
        end
        steady = 1'b0;
        s_valid <= 1'b0;

        // Drain: wait for every outstanding report, then a margin for strays.
        while (shadow.pending() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (shadow.failures == 0 && shadow.pending() == 0)
            $display("postfix_stack_calculator regression: pass");
        else
            $display("postfix_stack_calculator regression: fail");
        $finish;
    end

endmodule

[sim.f]
rtl/psc_pkg.sv
rtl/psc_ram.sv
rtl/psc_dpath.sv
rtl/psc_ctrl.sv
rtl/postfix_stack_calculator.sv
rtl/psc_checker.sv
bench/postfix_stack_calculator_test.sv
